>>> rtl/aef_pkg.sv
// shared types, constants and character classes of the escape sequence filter
package aef_pkg;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_COLOUR   = 8'h6D;

  localparam logic [1:0] MODE_STRIP  = 2'd0;
  localparam logic [1:0] MODE_COLOUR = 2'd1;
  localparam logic [1:0] MODE_CMDS   = 2'd2;

  // command queue between parser and emitter
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_ESC,
    PH_SEQ
  } phase_e;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_RUN,
    CMD_END
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EMIT
  } back_state_e;

  // data is the character for CMD_CHAR and the run length for CMD_RUN
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  // digits, ';' and '='
  function automatic logic is_param(input logic [7:0] c);
    logic r;
    case (c) inside
      [8'h30:8'h39], 8'h3B, 8'h3D: r = 1'b1;
      default:                     r = 1'b0;
    endcase
    return r;
  endfunction

  // A B C D H I J K f h l m s u
  function automatic logic is_cmd(input logic [7:0] c);
    logic r;
    case (c) inside
      [8'h41:8'h44], [8'h48:8'h4B], 8'h66, 8'h68, 8'h6C, 8'h6D, 8'h73, 8'h75: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/aef_ram.sv
// generic single write port ram with registered read
module aef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/aef_front.sv
// parser: accepts characters, tracks escape state, buffers sequences, queues commands
module aef_front #(
  parameter int SEQ_MAX = 32,
  localparam int AW = $clog2(SEQ_MAX),
  localparam int LW = $clog2(SEQ_MAX + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       filter_mode_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_char_i,
  input  logic             is_end_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output aef_pkg::cmd_t    q_cmd_o,
  input  logic             run_done_i,
  output logic             buf_we_o,
  output logic [AW-1:0]    buf_waddr_o,
  output logic [7:0]       buf_wdata_o
);

  aef_pkg::phase_e phase_q, phase_d;
  logic [1:0]      mode_q;
  logic [LW-1:0]   len_q, len_d;
  logic            ovf_q, ovf_d;
  logic            run_pend_q, run_pend_d;
  logic            accept;
  logic            keep;
  logic            full_buf;

  assign cfg_ready_o = 1'b1;

  // sequence characters wait until the previous run has been read out
  assign in_ready_o = !q_full_i && !((phase_q == aef_pkg::PH_SEQ) && run_pend_q);
  assign accept     = in_valid_i && in_ready_o;
  assign full_buf   = (len_q == LW'(SEQ_MAX));

  assign keep = ((mode_q == aef_pkg::MODE_CMDS) && aef_pkg::is_cmd(in_char_i)) ||
                ((mode_q == aef_pkg::MODE_COLOUR) && (in_char_i == aef_pkg::CH_COLOUR));

  // next state
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      if (is_end_i) begin
        phase_d = aef_pkg::PH_TEXT;
      end else begin
        case (phase_q)
          aef_pkg::PH_TEXT: begin
            if (in_char_i == aef_pkg::CH_ESC) phase_d = aef_pkg::PH_ESC;
          end
          aef_pkg::PH_ESC: begin
            phase_d = (in_char_i == aef_pkg::CH_LBRACKET) ? aef_pkg::PH_SEQ
                                                          : aef_pkg::PH_TEXT;
          end
          default: begin
            if (!aef_pkg::is_param(in_char_i)) phase_d = aef_pkg::PH_TEXT;
          end
        endcase
      end
    end
  end

  // outputs and buffer bookkeeping
  always_comb begin
    q_push_o      = 1'b0;
    q_cmd_o.kind  = aef_pkg::CMD_CHAR;
    q_cmd_o.data  = in_char_i;
    buf_we_o      = 1'b0;
    buf_waddr_o   = len_q[AW-1:0];
    buf_wdata_o   = in_char_i;
    len_d         = len_q;
    ovf_d         = ovf_q;
    if (accept) begin
      if (is_end_i) begin
        q_push_o     = 1'b1;
        q_cmd_o.kind = aef_pkg::CMD_END;
        q_cmd_o.data = 8'd0;
        len_d        = '0;
        ovf_d        = 1'b0;
      end else begin
        case (phase_q)
          aef_pkg::PH_TEXT: begin
            q_push_o = (in_char_i != aef_pkg::CH_ESC);
          end
          aef_pkg::PH_ESC: begin
            // esc and bracket sit at slots 0 and 1, filled in by the emitter
            len_d = LW'(2);
            ovf_d = 1'b0;
          end
          default: begin
            buf_we_o = !full_buf;
            if (aef_pkg::is_param(in_char_i)) begin
              if (full_buf) ovf_d = 1'b1;
              else          len_d = len_q + LW'(1);
            end else begin
              q_push_o     = keep && !ovf_q && !full_buf;
              q_cmd_o.kind = aef_pkg::CMD_RUN;
              q_cmd_o.data = 8'(len_q + LW'(1));
              len_d        = '0;
              ovf_d        = 1'b0;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    run_pend_d = run_pend_q;
    if (q_push_o && (q_cmd_o.kind == aef_pkg::CMD_RUN)) run_pend_d = 1'b1;
    else if (run_done_i)                                 run_pend_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= aef_pkg::PH_TEXT;
      mode_q     <= aef_pkg::MODE_STRIP;
      len_q      <= '0;
      ovf_q      <= 1'b0;
      run_pend_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      len_q      <= len_d;
      ovf_q      <= ovf_d;
      run_pend_q <= run_pend_d;
      if (cfg_valid_i && cfg_ready_o) mode_q <= filter_mode_i;
    end
  end

endmodule

>>> rtl/aef_cmd_fifo.sv
// small command queue between parser and emitter
module aef_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  aef_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output aef_pkg::cmd_t cmd_o
);

  aef_pkg::cmd_t               slot_q [aef_pkg::QDEPTH];
  logic [aef_pkg::QPW-1:0]     wptr_q, rptr_q;
  logic [aef_pkg::QCW-1:0]     cnt_q;

  assign full_o  = (cnt_q == aef_pkg::QCW'(aef_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == aef_pkg::QPW'(aef_pkg::QDEPTH - 1)) ? '0
                                                                 : wptr_q + aef_pkg::QPW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == aef_pkg::QPW'(aef_pkg::QDEPTH - 1)) ? '0
                                                                 : rptr_q + aef_pkg::QPW'(1);
      end
      if (push_i && !pop_i)      cnt_q <= cnt_q + aef_pkg::QCW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - aef_pkg::QCW'(1);
    end
  end

endmodule

>>> rtl/aef_back.sv
// emitter: carries out queued commands, reads runs from the buffer, keeps the count
module aef_back #(
  parameter int SEQ_MAX    = 32,
  parameter int COUNT_BITS = 16,
  localparam int AW = $clog2(SEQ_MAX),
  localparam int LW = $clog2(SEQ_MAX + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  aef_pkg::cmd_t         q_cmd_i,
  output logic                  q_pop_o,
  output logic                  run_done_o,
  output logic                  buf_re_o,
  output logic [AW-1:0]         buf_raddr_o,
  input  logic [7:0]            buf_rdata_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_char_o,
  output logic                  out_run_last_o,
  output logic                  out_end_o,
  output logic [COUNT_BITS-1:0] kept_count_o
);

  aef_pkg::back_state_e state_q, state_d;
  logic [LW-1:0]         idx_q, idx_d;
  logic [LW-1:0]         len_q, len_d;
  logic [COUNT_BITS-1:0] total_q, total_d, total_inc;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;
  logic                  out_end_q, out_end_d;
  logic [COUNT_BITS-1:0] out_cnt_q, out_cnt_d;
  logic                  load;
  logic                  out_free;
  logic                  run_last;
  logic [7:0]            run_char;

  assign out_free  = !out_valid_q || out_ready_i;
  assign total_inc = (total_q == '1) ? total_q : total_q + COUNT_BITS'(1);
  assign run_last  = ((idx_q + LW'(1)) == len_q);

  always_comb begin
    if (idx_q == LW'(0))      run_char = aef_pkg::CH_ESC;
    else if (idx_q == LW'(1)) run_char = aef_pkg::CH_LBRACKET;
    else                      run_char = buf_rdata_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      aef_pkg::BK_IDLE: begin
        if (q_valid_i && (q_cmd_i.kind == aef_pkg::CMD_RUN)) state_d = aef_pkg::BK_READ;
      end
      aef_pkg::BK_READ: state_d = aef_pkg::BK_EMIT;
      aef_pkg::BK_EMIT: begin
        if (out_free) state_d = run_last ? aef_pkg::BK_IDLE : aef_pkg::BK_READ;
      end
      default: state_d = aef_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop_o     = 1'b0;
    run_done_o  = 1'b0;
    buf_re_o    = 1'b0;
    buf_raddr_o = idx_q[AW-1:0];
    load        = 1'b0;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_end_d   = out_end_q;
    out_cnt_d   = out_cnt_q;
    total_d     = total_q;
    idx_d       = idx_q;
    len_d       = len_q;
    case (state_q)
      aef_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          case (q_cmd_i.kind)
            aef_pkg::CMD_RUN: begin
              q_pop_o = 1'b1;
              idx_d   = '0;
              len_d   = q_cmd_i.data[LW-1:0];
            end
            aef_pkg::CMD_END: begin
              if (out_free) begin
                q_pop_o    = 1'b1;
                load       = 1'b1;
                out_char_d = 8'd0;
                out_last_d = 1'b1;
                out_end_d  = 1'b1;
                out_cnt_d  = total_q;
                total_d    = '0;
              end
            end
            default: begin
              if (out_free) begin
                q_pop_o    = 1'b1;
                load       = 1'b1;
                out_char_d = q_cmd_i.data;
                out_last_d = 1'b1;
                out_end_d  = 1'b0;
                out_cnt_d  = total_inc;
                total_d    = total_inc;
              end
            end
          endcase
        end
      end
      aef_pkg::BK_READ: begin
        buf_re_o = 1'b1;
      end
      aef_pkg::BK_EMIT: begin
        if (out_free) begin
          load       = 1'b1;
          out_char_d = run_char;
          out_last_d = run_last;
          out_end_d  = 1'b0;
          out_cnt_d  = total_inc;
          total_d    = total_inc;
          idx_d      = idx_q + LW'(1);
          run_done_o = run_last;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (load)             out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aef_pkg::BK_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      len_q       <= '0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
      out_end_q  <= out_end_d;
      out_cnt_q  <= out_cnt_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_char_o     = out_char_q;
  assign out_run_last_o = out_last_q;
  assign out_end_o      = out_end_q;
  assign kept_count_o   = out_cnt_q;

endmodule

>>> rtl/ansi_escape_filter_top.sv
// Escape sequence filter: a parser front end feeds a two-entry command queue, and an emitter
// back end drives the registered output. Plain text and end requests flow at one character
// per cycle while no run is read out and the output is ready. Escape sequences (ESC '['
// parameters final) are stored in a buffer memory of SEQ_MAX bytes; a kept sequence leaves
// as a burst, each character passing the buffer's registered read and then the output
// load. While a run is being read out, the next sequence's characters after its '[' wait
// at the input; plain text and end requests keep flowing into the queue. A sequence longer
// than SEQ_MAX or unterminated at the end request is dropped; kept_count saturates. Mode
// writes are taken at any time and never stall; the buffer needs no clearing after reset.
module ansi_escape_filter_top #(
  parameter int SEQ_MAX    = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            filter_mode_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            in_char_i,
  input  logic                  is_end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_char_o,
  output logic                  out_run_last_o,
  output logic                  out_end_o,
  output logic [COUNT_BITS-1:0] kept_count_o
);

  localparam int AW = $clog2(SEQ_MAX);

  logic          q_full, q_push, q_pop, q_valid;
  aef_pkg::cmd_t q_cmd_in, q_cmd_out;
  logic          run_done;
  logic          buf_we, buf_re;
  logic [AW-1:0] buf_waddr, buf_raddr;
  logic [7:0]    buf_wdata, buf_rdata;

  aef_front #(.SEQ_MAX(SEQ_MAX)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .filter_mode_i(filter_mode_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_char_i    (in_char_i),
    .is_end_i     (is_end_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_cmd_in),
    .run_done_i   (run_done),
    .buf_we_o     (buf_we),
    .buf_waddr_o  (buf_waddr),
    .buf_wdata_o  (buf_wdata)
  );

  aef_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (q_cmd_out)
  );

  aef_ram #(.WIDTH(8), .DEPTH(SEQ_MAX)) u_seq_buf (
    .clk_i  (clk_i),
    .we_i   (buf_we),
    .waddr_i(buf_waddr),
    .wdata_i(buf_wdata),
    .re_i   (buf_re),
    .raddr_i(buf_raddr),
    .rdata_o(buf_rdata)
  );

  aef_back #(.SEQ_MAX(SEQ_MAX), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd_out),
    .q_pop_o       (q_pop),
    .run_done_o    (run_done),
    .buf_re_o      (buf_re),
    .buf_raddr_o   (buf_raddr),
    .buf_rdata_i   (buf_rdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_char_o    (out_char_o),
    .out_run_last_o(out_run_last_o),
    .out_end_o     (out_end_o),
    .kept_count_o  (kept_count_o)
  );

endmodule

>>> rtl/aef_checker.sv
// port level checks of the escape sequence filter, bound to the top level
module aef_checker #(
  parameter int COUNT_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [7:0]            out_char_o,
  input logic                  out_run_last_o,
  input logic                  out_end_o,
  input logic [COUNT_BITS-1:0] kept_count_o
);

  // a stalled request keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o) &&
      $stable(out_run_last_o) && $stable(out_end_o) && $stable(kept_count_o))
    else $error("output request changed while stalled");

  // the end result closes its run and carries no character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_end_o |-> out_run_last_o && (out_char_o == 8'd0))
    else $error("end result malformed");

  // every kept character has been counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_end_o |-> kept_count_o != '0)
    else $error("kept character with zero count");

  // a character presented right after an end result is taken is the first of the new string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_end_o ##1 out_valid_o && !out_end_o
      |-> kept_count_o == COUNT_BITS'(1))
    else $error("count not restarted after end result");

endmodule

bind ansi_escape_filter_top aef_checker #(.COUNT_BITS(COUNT_BITS)) u_aef_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_char_o    (out_char_o),
  .out_run_last_o(out_run_last_o),
  .out_end_o     (out_end_o),
  .kept_count_o  (kept_count_o)
);
